// ===== rtl/core/fifo_queue_with_remove_by_key_defines.svh =====
// Assertion macros for the key queue.
// Used by fifo_queue_with_remove_by_key.sv; needs clk_i and rst_ni in scope.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_KEY_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_KEY_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is released.
`define FQRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define FQRK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FQRK_ASSERT(lbl, prop, msg)
`define FQRK_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/fqrk_pkg.sv =====
// Shared types and constants for the key queue.
// No dependencies; used by the interfaces, the cell and the top level.
package fqrk_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned STS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REM = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
    logic rem;
  } ctrl_t;

endpackage

// ===== rtl/core/fqrk_if.sv =====
// Valid/ready channel interfaces for commands and responses.
// Depends on fqrk_pkg.
interface fqrk_cmd_if;
  import fqrk_pkg::*;

  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [KEY_W-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface fqrk_rsp_if;
  import fqrk_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic [KEY_W-1:0]   out_key;
  logic [CNT_W-1:0]   entry_count;
  logic               is_empty;

  modport source (output valid, output status, output out_key, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input out_key, input entry_count,
                  input is_empty, output ready);
endinterface

// ===== rtl/core/fqrk_cell.sv =====
// One slot of the queue: holds a key, compares it and shifts towards the head.
// Depends on fqrk_pkg.
module fqrk_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned IDX      = 0
) (
  input  logic                  clk_i,
  input  fqrk_pkg::ctrl_t       ctrl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic                  found_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic                  found_o
);
  import fqrk_pkg::*;

  logic [KEY_BITS-1:0] key_q;
  logic                occupied;
  logic                match;
  logic                shift;
  logic                load;

  assign occupied = CNT_W'(IDX) < count_i;
  assign match    = occupied && (key_q == key_i);
  assign found_o  = found_i | match;

  // Every cell takes its neighbour's key on a dequeue; on a removal, every cell at or behind the removed entry does.
  assign shift = ctrl_i.deq | (ctrl_i.rem & (found_i | match));
  assign load  = ctrl_i.enq & (count_i == CNT_W'(IDX));

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q <= next_key_i;
    end else if (load) begin
      key_q <= key_i;
    end
  end

  assign key_o = key_q;

endmodule

// ===== rtl/core/fifo_queue_with_remove_by_key.sv =====
// Top level of the key queue: a row of cells, occupancy count and response register.
// Depends on fqrk_pkg, fqrk_if, fqrk_cell and the defines header.
//
//  channel  dir  words carried
//  cmd_i    in   command, key
//  rsp_o    out  status, out_key, entry_count, is_empty
//
// One command is taken per cycle; its response appears in the following cycle.
// The rate is set by the cell row, which compares all keys and shifts in one step.
// A command is taken while the response register is empty or being read out.
// Reset clears the occupancy count and the response valid; slot contents are not reset.
`include "fifo_queue_with_remove_by_key_defines.svh"

module fifo_queue_with_remove_by_key #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqrk_cmd_if.sink   cmd_i,
  fqrk_rsp_if.source rsp_o
);
  import fqrk_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                 acc;
  ctrl_t                ctrl;
  logic [KEY_BITS-1:0]  key_k;
  logic [KEY_BITS-1:0]  key_chain [DEPTH+1];
  logic                 found_chain [DEPTH+1];
  logic                 found;
  logic [CW-1:0]        count_q, count_d;
  logic                 not_empty;
  logic                 not_full;
  status_e              status_d;
  logic [KEY_W-1:0]     head_key;
  logic [CNT_W-1:0]     count_out;

  logic                 rsp_v_q;
  status_e              status_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 empty_q;

  assign cmd_i.ready = ~rsp_v_q | rsp_o.ready;
  assign acc         = cmd_i.valid & cmd_i.ready;

  generate
    if (KEY_BITS > KEY_W) begin : g_key_ext
      assign key_k    = {{(KEY_BITS - KEY_W){1'b0}}, cmd_i.key};
      assign head_key = key_chain[0][KEY_W-1:0];
    end else if (KEY_BITS == KEY_W) begin : g_key_eq
      assign key_k    = cmd_i.key;
      assign head_key = key_chain[0];
    end else begin : g_key_trunc
      assign key_k    = cmd_i.key[KEY_BITS-1:0];
      assign head_key = {{(KEY_W - KEY_BITS){1'b0}}, key_chain[0]};
    end
  endgenerate

  assign not_empty = count_q != '0;
  assign not_full  = count_q < CW'(DEPTH);

  assign ctrl.enq = acc & (cmd_i.command == CMD_ENQ);
  assign ctrl.deq = acc & (cmd_i.command == CMD_DEQ) & not_empty;
  assign ctrl.rem = acc & (cmd_i.command == CMD_REM);

  assign key_chain[DEPTH]  = '0;
  assign found_chain[0]    = 1'b0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      fqrk_cell #(
        .KEY_BITS (KEY_BITS),
        .CNT_W    (CW),
        .IDX      (i)
      ) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .key_i      (key_k),
        .count_i    (count_q),
        .next_key_i (key_chain[i+1]),
        .found_i    (found_chain[i]),
        .key_o      (key_chain[i]),
        .found_o    (found_chain[i+1])
      );
    end
  endgenerate

  assign found = found_chain[DEPTH];

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    case (cmd_i.command)
      CMD_ENQ: begin
        if (not_full) count_d = count_q + CW'(1);
        else          status_d = ST_FULL;
      end
      CMD_DEQ: begin
        if (not_empty) count_d = count_q - CW'(1);
        else           status_d = ST_EMPTY;
      end
      CMD_REM: begin
        if (found) count_d = count_q - CW'(1);
        else       status_d = ST_NOTFOUND;
      end
      CMD_CLR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  generate
    if (CW >= CNT_W) begin : g_cnt_trunc
      assign count_out = count_d[CNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_out = {{(CNT_W - CW){1'b0}}, count_d};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
        rsp_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q  <= status_d;
      out_key_q <= ctrl.deq ? head_key : '0;
      cnt_q     <= count_out;
      empty_q   <= count_d == '0;
    end
  end

  assign rsp_o.valid       = rsp_v_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.entry_count = cnt_q;
  assign rsp_o.is_empty    = empty_q;

  `FQRK_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= CW'(DEPTH), "occupancy above depth")
  `FQRK_ASSERT(a_enq_grows, ctrl.enq && not_full |=> count_q == $past(count_q) + CW'(1), "enq lost")
  `FQRK_ASSERT(a_rem_shrinks, ctrl.rem && found |=> count_q == $past(count_q) - CW'(1), "rem lost")
  `FQRK_ASSERT(a_clr_empties, acc && cmd_i.command == CMD_CLR |=> count_q == '0, "clear missed")
  `FQRK_ASSERT(a_stall_blocks, rsp_v_q && !rsp_o.ready |-> !cmd_i.ready, "taken while stalled")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the key queue: a directed opening, then random command words.
// Responses are checked against a queue-based prediction; needs fqrk_pkg, fqrk_if and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fqrk_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CALM_TAIL   = 150;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } cmd_word_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } rsp_word_t;

  logic clk_i;
  logic rst_ni;

  fqrk_cmd_if cmd_ch ();
  fqrk_rsp_if rsp_ch ();

  fifo_queue_with_remove_by_key dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  cmd_word_t        pending_cmds[$];
  rsp_word_t        awaited_rsps[$];
  logic [KEY_W-1:0] held_keys[$];
  logic [KEY_W-1:0] recent_keys[$];
  int               n_items;
  int               n_taken;
  int               n_fails;
  int               send_gap;
  int               sink_stall;
  logic             cmd_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Mirror of the queue contents: entry 0 is the head.
  function automatic rsp_word_t apply_queue_command(cmd_word_t c);
    rsp_word_t r;
    int        hit;
    r.status  = ST_OK;
    r.out_key = '0;
    hit       = -1;
    case (c.command)
      CMD_ENQ: begin
        if (held_keys.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else held_keys.push_back(c.key);
      end
      CMD_DEQ: begin
        if (held_keys.size() == 0) r.status = ST_EMPTY;
        else r.out_key = held_keys.pop_front();
      end
      CMD_REM: begin
        for (int i = 0; i < held_keys.size() && hit < 0; i++) begin
          if (held_keys[i] == c.key) hit = i;
        end
        if (hit < 0) r.status = ST_NOTFOUND;
        else held_keys.delete(hit);
      end
      default: begin
        held_keys.delete();
      end
    endcase
    r.entry_count = CNT_W'(held_keys.size());
    r.is_empty    = (held_keys.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_fails++;
  endtask

  task automatic queue_cmd(cmd_e c, logic [KEY_W-1:0] k);
    pending_cmds.push_back('{command: c, key: k});
    n_items++;
    if (c == CMD_ENQ) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end
  endtask

  // Command driver: a new word is presented once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!cmd_ch.valid || cmd_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 2);
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd_word_t w;
        w = pending_cmds.pop_front();
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= w.command;
        cmd_ch.key     <= w.key;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure in short bursts, dropped for the tail of the run.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: the prediction is pushed before the check, so ordering holds at any latency.
  always @(posedge clk_i) begin
    rsp_word_t want;
    if (rst_ni) begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        awaited_rsps.push_back(apply_queue_command('{command: cmd_ch.command, key: cmd_ch.key}));
        n_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch("unexpected response, status", KEY_W'(rsp_ch.status), '0);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", KEY_W'(rsp_ch.status), KEY_W'(want.status));
          if (rsp_ch.out_key !== want.out_key)
            report_mismatch("out_key", rsp_ch.out_key, want.out_key);
          if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", KEY_W'(rsp_ch.entry_count), KEY_W'(want.entry_count));
          if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", KEY_W'(rsp_ch.is_empty), KEY_W'(want.is_empty));
        end
      end
    end
  end

  initial begin
    int               enq_weight;
    int               pick;
    logic [KEY_W-1:0] k;
    rst_ni         = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_ENQ;
    cmd_ch.key     = '0;
    rsp_ch.ready   = 1'b0;
    cmd_taken      = 1'b0;
    send_gap       = 0;
    sink_stall     = 0;
    n_items        = 0;
    n_taken        = 0;
    n_fails        = 0;

    // Directed opening: operations on an empty list, extreme keys, duplicates, filling up.
    queue_cmd(CMD_DEQ, 32'hFFFF_FFFF);
    queue_cmd(CMD_REM, 32'h0000_0000);
    queue_cmd(CMD_CLR, 32'hA5A5_5A5A);
    queue_cmd(CMD_ENQ, 32'h0000_0000);
    queue_cmd(CMD_ENQ, 32'hFFFF_FFFF);
    queue_cmd(CMD_ENQ, 32'h0000_0005);
    queue_cmd(CMD_ENQ, 32'h0000_0000);
    queue_cmd(CMD_REM, 32'h0000_0000);
    queue_cmd(CMD_DEQ, 32'h1234_5678);
    queue_cmd(CMD_REM, 32'h0000_1234);
    queue_cmd(CMD_REM, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) queue_cmd(CMD_ENQ, $urandom);
    queue_cmd(CMD_ENQ, 32'hDEAD_BEEF);
    queue_cmd(CMD_CLR, 32'h0000_0000);

    // Random part in segments that lean towards filling, balance or draining.
    for (int seg = 0; seg < 33; seg++) begin
      case ($urandom_range(0, 2))
        0:       enq_weight = 70;
        1:       enq_weight = 45;
        default: enq_weight = 20;
      endcase
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        k    = $urandom;
        if (pick < 3) begin
          queue_cmd(CMD_CLR, k);
        end else if (pick < 3 + enq_weight) begin
          // A small pool of keys makes duplicates common.
          case ($urandom_range(0, 9))
            0:       k = '0;
            1:       k = '1;
            2, 3:    k = $urandom_range(0, 3);
            default: k = $urandom;
          endcase
          queue_cmd(CMD_ENQ, k);
        end else if ($urandom_range(0, 1) == 0) begin
          queue_cmd(CMD_DEQ, k);
        end else begin
          if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0)
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
          queue_cmd(CMD_REM, k);
        end
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_taken == n_items && awaited_rsps.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_fails == 0 && awaited_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
